>>> src/tcp_echo_latency_stamp_assert.svh
// ----------------------------------------------------------------------------
// tcp_echo_latency_stamp assertion macros
// concurrent checks on the rising edge of clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TCP_ECHO_LATENCY_STAMP_ASSERT_SVH
`define TCP_ECHO_LATENCY_STAMP_ASSERT_SVH

// same-cycle implication
`define TELS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TELS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/tels_pkg.sv
// ----------------------------------------------------------------------------
// tels_pkg
// beat types and result kind codes for the tcp echo latency stamp block
// ----------------------------------------------------------------------------
package tels_pkg;

  // default capacity of the message store in 64-byte words
  localparam int MAX_WORDS_DEF = 64;

  localparam int LANES      = 8;
  localparam int LANE_W     = 64;
  localparam int WORD_W     = LANES * LANE_W;
  localparam int OUT_LEN_W  = 13;

  // input function codes
  localparam logic [2:0] FUNC_IDLE   = 3'd0;
  localparam logic [2:0] FUNC_NOTIFY = 3'd1;
  localparam logic [2:0] FUNC_RXMETA = 3'd2;
  localparam logic [2:0] FUNC_RXDATA = 3'd3;
  localparam logic [2:0] FUNC_STATUS = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_TXMETA = 2'd1;
  localparam logic [1:0] KIND_TXDATA = 2'd2;

  // tx status codes (low two bits)
  localparam logic [1:0] STAT_SEND = 2'd0;
  localparam logic [1:0] STAT_DROP = 2'd1;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] session_id;
    logic [15:0] value;
    logic        in_last;
    logic [63:0] in_lane_0;
    logic [63:0] in_lane_1;
    logic [63:0] in_lane_2;
    logic [63:0] in_lane_3;
    logic [63:0] in_lane_4;
    logic [63:0] in_lane_5;
    logic [63:0] in_lane_6;
    logic [63:0] in_lane_7;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [15:0]          out_session;
    logic [OUT_LEN_W-1:0] out_length;
    logic                 out_last;
    logic [63:0]          out_lane_0;
    logic [63:0]          out_lane_1;
    logic [63:0]          out_lane_2;
    logic [63:0]          out_lane_3;
    logic [63:0]          out_lane_4;
    logic [63:0]          out_lane_5;
    logic [63:0]          out_lane_6;
    logic [63:0]          out_lane_7;
  } out_beat_t;

endpackage

>>> src/tcp_echo_latency_stamp.sv
// ----------------------------------------------------------------------------
// tcp_echo_latency_stamp
// tcp echo sequencer that stamps the echoed message with its latency
// ----------------------------------------------------------------------------
// Usage: one beat on in_item is one step of the sequencer, taken when start
// is high and busy is low. busy stays low, so a beat may come every cycle.
// A beat carries a stack event (notification, rx metadata, rx data word,
// tx status) or an idle tick; events that do not fit the current phase are
// dropped. A beat gives at most one result, shown on out_item with
// out_strobe high for exactly one cycle, in the cycle after the beat is taken.
// The receiver cannot stall; the result register is free again each cycle.
// Received words go into a memory of MAX_WORDS entries, 512 bits wide, with
// one write port and one registered read port, one word per write. During
// the echo the read address is the next send index, so the word for the
// following beat is already in the read register: one beat per cycle.
// The stamp counts accepted beats, not clock cycles, and adds the number of stored words.
// Reset (rst_n low, synchronous) returns the sequencer to waiting for a
// notification and clears the counters; the memory keeps its contents and
// needs no clearing pass, since an echo only reads words of its message.
// ----------------------------------------------------------------------------
module tcp_echo_latency_stamp
  import tels_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_item,
  output logic      out_strobe,
  output out_beat_t out_item
);

  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW  = $clog2(MAX_WORDS + 1);
  localparam int CAP = MAX_WORDS * 64;
  localparam int LW  = $clog2(CAP + 1);

  // phase codes
  localparam logic [2:0] PH_NOTIFY = 3'd0;
  localparam logic [2:0] PH_META   = 3'd1;
  localparam logic [2:0] PH_RX     = 3'd2;
  localparam logic [2:0] PH_REQ    = 3'd3;
  localparam logic [2:0] PH_STATUS = 3'd4;
  localparam logic [2:0] PH_TX     = 3'd5;

  // message store and its registered read port
  logic [WORD_W-1:0] mem [MAX_WORDS];
  logic [WORD_W-1:0] rd_word_r;
  logic              mem_we;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] wr_word;

  logic [2:0]    phase_r,      phase_nxt;
  logic [15:0]   session_r,    session_nxt;
  logic [LW-1:0] msg_bytes_r,  msg_bytes_nxt;
  logic [LW-1:0] send_bytes_r, send_bytes_nxt;
  logic [CW-1:0] stored_r,     stored_nxt;
  logic [CW-1:0] send_idx_r,   send_idx_nxt;
  logic [LW-1:0] left_r,       left_nxt;
  logic [31:0]   cycle_r,      cycle_nxt;
  logic [31:0]   start_time_r, start_time_nxt;
  logic [31:0]   latency_r,    latency_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  out_beat_t     out_item_r,   out_item_nxt;

  logic          accept;
  logic [LW-1:0] word_bytes;
  logic [CW-1:0] idx_inc;
  logic [6:0]    valid_bytes;
  logic [31:0]   stamp;
  logic [63:0]   lane0;

  assign busy       = 1'b0;
  assign accept     = start & ~busy;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  assign wr_word = {in_item.in_lane_7, in_item.in_lane_6, in_item.in_lane_5,
                    in_item.in_lane_4, in_item.in_lane_3, in_item.in_lane_2,
                    in_item.in_lane_1, in_item.in_lane_0};
  assign wr_addr = stored_r[AW-1:0];

  // bytes held by the stored words
  assign word_bytes = LW'(stored_r) << 6;
  assign idx_inc    = send_idx_r + CW'(1);
  assign valid_bytes = (left_r >= LW'(64)) ? 7'd64 : 7'(left_r);

  // latency stamp, all-ones reserved as a marker
  assign stamp = (latency_r == 32'hFFFF_FFFF) ? 32'hFFFF_FFFE : latency_r;
  assign lane0 = (send_idx_r == '0)
               ? {rd_word_r[63:32], stamp[7:0], stamp[15:8], stamp[23:16], stamp[31:24]}
               : rd_word_r[63:0];

  // next read address follows the send index one beat ahead
  assign rd_addr = (send_idx_nxt < CW'(MAX_WORDS)) ? send_idx_nxt[AW-1:0] : '0;

  // sequencer step
  always_comb begin
    phase_nxt      = phase_r;
    session_nxt    = session_r;
    msg_bytes_nxt  = msg_bytes_r;
    send_bytes_nxt = send_bytes_r;
    stored_nxt     = stored_r;
    send_idx_nxt   = send_idx_r;
    left_nxt       = left_r;
    cycle_nxt      = cycle_r;
    start_time_nxt = start_time_r;
    latency_nxt    = latency_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    mem_we         = 1'b0;
    if (accept) begin
      cycle_nxt = cycle_r + 32'd1;
      unique case (phase_r)
        PH_NOTIFY: begin
          if (in_item.func == FUNC_NOTIFY && in_item.value != 16'd0) begin
            start_time_nxt = cycle_nxt;
            session_nxt    = in_item.session_id;
            msg_bytes_nxt  = (32'(in_item.value) > 32'(CAP)) ? LW'(CAP)
                                                               : LW'(in_item.value);
            stored_nxt     = '0;
            phase_nxt      = PH_META;
            out_strobe_nxt           = 1'b1;
            out_item_nxt.kind        = KIND_READ;
            out_item_nxt.out_session = session_nxt;
            out_item_nxt.out_length  = OUT_LEN_W'(msg_bytes_nxt);
          end
        end
        PH_META: begin
          if (in_item.func == FUNC_RXMETA) begin
            phase_nxt = PH_RX;
          end
        end
        PH_RX: begin
          if (in_item.func == FUNC_RXDATA) begin
            if (stored_r < CW'(MAX_WORDS)) begin
              mem_we     = 1'b1;
              stored_nxt = stored_r + CW'(1);
            end
            if (in_item.in_last) begin
              phase_nxt = PH_REQ;
            end
          end
        end
        PH_REQ: begin
          send_bytes_nxt = (msg_bytes_r < word_bytes) ? msg_bytes_r : word_bytes;
          phase_nxt      = PH_STATUS;
          out_strobe_nxt           = 1'b1;
          out_item_nxt.kind        = KIND_TXMETA;
          out_item_nxt.out_session = session_r;
          out_item_nxt.out_length  = OUT_LEN_W'(send_bytes_nxt);
        end
        PH_STATUS: begin
          if (in_item.func == FUNC_STATUS) begin
            if (in_item.value[1:0] == STAT_SEND) begin
              send_idx_nxt = '0;
              left_nxt     = send_bytes_r;
              latency_nxt  = (cycle_nxt - start_time_r) + 32'(stored_r);
              phase_nxt    = PH_TX;
            end else if (in_item.value[1:0] == STAT_DROP) begin
              phase_nxt = PH_NOTIFY;
            end else begin
              phase_nxt = PH_REQ;
            end
          end
        end
        PH_TX: begin
          left_nxt     = (left_r >= LW'(64)) ? left_r - LW'(64) : '0;
          send_idx_nxt = idx_inc;
          out_strobe_nxt          = 1'b1;
          out_item_nxt.kind       = KIND_TXDATA;
          out_item_nxt.out_length = OUT_LEN_W'(valid_bytes);
          out_item_nxt.out_last   = (idx_inc >= stored_r);
          out_item_nxt.out_lane_0 = lane0;
          out_item_nxt.out_lane_1 = rd_word_r[1*LANE_W +: LANE_W];
          out_item_nxt.out_lane_2 = rd_word_r[2*LANE_W +: LANE_W];
          out_item_nxt.out_lane_3 = rd_word_r[3*LANE_W +: LANE_W];
          out_item_nxt.out_lane_4 = rd_word_r[4*LANE_W +: LANE_W];
          out_item_nxt.out_lane_5 = rd_word_r[5*LANE_W +: LANE_W];
          out_item_nxt.out_lane_6 = rd_word_r[6*LANE_W +: LANE_W];
          out_item_nxt.out_lane_7 = rd_word_r[7*LANE_W +: LANE_W];
          if (idx_inc >= stored_r) begin
            phase_nxt = PH_NOTIFY;
          end
        end
        default: begin
          phase_nxt = PH_NOTIFY;
        end
      endcase
    end
  end

  // message store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_word;
    end
    rd_word_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_NOTIFY;
      session_r    <= '0;
      msg_bytes_r  <= '0;
      send_bytes_r <= '0;
      stored_r     <= '0;
      send_idx_r   <= '0;
      left_r       <= '0;
      cycle_r      <= '0;
      start_time_r <= '0;
      latency_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      session_r    <= session_nxt;
      msg_bytes_r  <= msg_bytes_nxt;
      send_bytes_r <= send_bytes_nxt;
      stored_r     <= stored_nxt;
      send_idx_r   <= send_idx_nxt;
      left_r       <= left_nxt;
      cycle_r      <= cycle_nxt;
      start_time_r <= start_time_nxt;
      latency_r    <= latency_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

endmodule

>>> src/tels_chk.sv
// ----------------------------------------------------------------------------
// tels_chk
// port-level checks on the result sequence of tcp_echo_latency_stamp
// ----------------------------------------------------------------------------
`include "tcp_echo_latency_stamp_assert.svh"

module tels_chk
  import tels_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_beat_t out_item
);

  logic beat_taken;
  logic read_beat;
  logic txmeta_beat;
  logic data_beat;
  logic echo_open;

  // result beat classes
  assign beat_taken  = start && !busy;
  assign read_beat   = out_strobe && out_item.kind == KIND_READ;
  assign txmeta_beat = out_strobe && out_item.kind == KIND_TXMETA;
  assign data_beat   = out_strobe && out_item.kind == KIND_TXDATA;
  assign echo_open   = data_beat && !out_item.out_last && beat_taken;

  // a result only follows an accepted beat
  `TELS_ASSERT_NOW(a_strobe_after_beat, out_strobe, $past(beat_taken), "result without a beat")

  // a read request is followed by the metadata wait, which gives nothing
  `TELS_ASSERT_NEXT(a_read_then_quiet, read_beat, !out_strobe, "result after read request")

  // a transmit request is followed by the status wait, which gives nothing
  `TELS_ASSERT_NEXT(a_txmeta_then_quiet, txmeta_beat, !out_strobe, "result after tx request")

  // an unfinished echo continues on the next beat
  `TELS_ASSERT_NEXT(a_echo_continues, echo_open, data_beat, "echo broke off before its last beat")

endmodule

bind tcp_echo_latency_stamp tels_chk u_tels_chk (.*);

>>> bench/tels_echo_checker.sv
// ----------------------------------------------------------------------------
// tels_echo_checker
// watches both channels of the tcp echo sequencer, keeps its own copy of
// the phase, message store and beat clock, and compares each result beat
// field by field with the oldest beat the block still owes
// ----------------------------------------------------------------------------
module tels_echo_checker
  import tels_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_beat_t  in_item,
  input  logic      out_strobe,
  input  out_beat_t out_item,
  output int        mismatches,
  output int        owed,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_WAIT_NOTIFY,
    PH_WAIT_META,
    PH_RECEIVE,
    PH_REQUEST,
    PH_WAIT_STATUS,
    PH_TRANSMIT
  } echo_phase_e;

  // sequencer state as the stack sees it
  echo_phase_e  ph;
  logic [511:0] word_mem [MAX_WORDS];
  logic [15:0]  sess;
  int unsigned  msg_bytes;
  int unsigned  snd_bytes;
  int unsigned  bytes_left;
  int unsigned  stored;
  int unsigned  sent;
  logic [31:0]  beat_clock;
  logic [31:0]  t_start;
  logic [31:0]  stamp;

  // result beats the block still owes, oldest first
  out_beat_t owed_beats[$];
  int        mismatch_tally;
  int        checked_tally;

  task automatic clear_echo_state();
    ph         = PH_WAIT_NOTIFY;
    sess       = '0;
    msg_bytes  = 0;
    snd_bytes  = 0;
    bytes_left = 0;
    stored     = 0;
    sent       = 0;
    beat_clock = '0;
    t_start    = '0;
    stamp      = '0;
    owed_beats.delete();
  endtask

  // one accepted beat moves the sequencer one step
  task automatic advance_echo(input in_beat_t b, output bit has, output out_beat_t r);
    logic [31:0]  v;
    logic [511:0] w;
    int unsigned  wb;
    int unsigned  valid;
    has = 1'b0;
    r   = '0;
    beat_clock = beat_clock + 32'd1;
    case (ph)
      PH_WAIT_NOTIFY: begin
        if (b.func == FUNC_NOTIFY && b.value != 16'd0) begin
          t_start   = beat_clock;
          sess      = b.session_id;
          msg_bytes = (b.value > MAX_WORDS * 64) ? MAX_WORDS * 64 : b.value;
          stored    = 0;
          ph        = PH_WAIT_META;
          has           = 1'b1;
          r.kind        = KIND_READ;
          r.out_session = sess;
          r.out_length  = OUT_LEN_W'(msg_bytes);
        end
      end
      PH_WAIT_META: begin
        if (b.func == FUNC_RXMETA) ph = PH_RECEIVE;
      end
      PH_RECEIVE: begin
        if (b.func == FUNC_RXDATA) begin
          // words past the store size are dropped, the message still ends on last
          if (stored < MAX_WORDS) begin
            word_mem[stored] = {b.in_lane_0, b.in_lane_1, b.in_lane_2, b.in_lane_3,
                                b.in_lane_4, b.in_lane_5, b.in_lane_6, b.in_lane_7};
            stored++;
          end
          if (b.in_last) ph = PH_REQUEST;
        end
      end
      PH_REQUEST: begin
        wb        = stored * 64;
        snd_bytes = (msg_bytes < wb) ? msg_bytes : wb;
        ph        = PH_WAIT_STATUS;
        has           = 1'b1;
        r.kind        = KIND_TXMETA;
        r.out_session = sess;
        r.out_length  = OUT_LEN_W'(snd_bytes);
      end
      PH_WAIT_STATUS: begin
        if (b.func == FUNC_STATUS) begin
          case (b.value[1:0])
            STAT_SEND: begin
              sent       = 0;
              bytes_left = snd_bytes;
              stamp      = (beat_clock - t_start) + stored;
              ph         = PH_TRANSMIT;
            end
            STAT_DROP: ph = PH_WAIT_NOTIFY;
            default:   ph = PH_REQUEST;
          endcase
        end
      end
      PH_TRANSMIT: begin
        w = word_mem[sent % MAX_WORDS];
        if (sent == 0) begin
          // all-ones is reserved, so the stamp steps down by one there
          v = (stamp == 32'hFFFF_FFFF) ? 32'hFFFF_FFFE : stamp;
          // bytes 0 to 3 of lane 0, most significant byte first
          w[479:448] = {v[7:0], v[15:8], v[23:16], v[31:24]};
        end
        valid      = (bytes_left >= 64) ? 64 : bytes_left;
        bytes_left = (bytes_left >= 64) ? bytes_left - 64 : 0;
        sent++;
        has          = 1'b1;
        r.kind       = KIND_TXDATA;
        r.out_length = OUT_LEN_W'(valid);
        r.out_last   = (sent >= stored);
        {r.out_lane_0, r.out_lane_1, r.out_lane_2, r.out_lane_3,
         r.out_lane_4, r.out_lane_5, r.out_lane_6, r.out_lane_7} = w;
        if (r.out_last) ph = PH_WAIT_NOTIFY;
      end
      default: ph = PH_WAIT_NOTIFY;
    endcase
  endtask

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatch_tally++;
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (owed_beats.size() == 0) begin
      report_mismatch("result beat with nothing owed", 64'(got.kind), 64'd0);
    end else begin
      want = owed_beats.pop_front();
      checked_tally++;
      if (got.kind !== want.kind)
        report_mismatch("kind", 64'(got.kind), 64'(want.kind));
      if (got.out_session !== want.out_session)
        report_mismatch("out_session", 64'(got.out_session), 64'(want.out_session));
      if (got.out_length !== want.out_length)
        report_mismatch("out_length", 64'(got.out_length), 64'(want.out_length));
      if (got.out_last !== want.out_last)
        report_mismatch("out_last", 64'(got.out_last), 64'(want.out_last));
      // lane i sits at bits [(7-i)*64 +: 64] of the packed beat
      for (int i = 0; i < LANES; i++)
        if (got[(7-i)*64 +: 64] !== want[(7-i)*64 +: 64])
          report_mismatch($sformatf("out_lane_%0d", i), got[(7-i)*64 +: 64],
                          want[(7-i)*64 +: 64]);
    end
  endtask

  initial begin
    mismatch_tally = 0;
    checked_tally  = 0;
    mismatches     = 0;
    owed           = 0;
    checked        = 0;
    clear_echo_state();
  end

  // results first, so a beat owed by this edge's input is not matched early
  always @(posedge clk) begin
    bit        has;
    out_beat_t r;
    if (!rst_n) begin
      clear_echo_state();
    end else begin
      if (out_strobe) check_result(out_item);
      if (start && !busy) begin
        advance_echo(in_item, has, r);
        if (has) owed_beats.push_back(r);
      end
    end
    mismatches <= mismatch_tally;
    owed       <= owed_beats.size();
    checked    <= checked_tally;
  end

endmodule

>>> bench/tb_tcp_echo_latency_stamp.sv
// ----------------------------------------------------------------------------
// tb_tcp_echo_latency_stamp
// drives notification, rx and status beats through whole echo exchanges,
// with stray events, drops, retries, overlong messages and random idling;
// the checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_tcp_echo_latency_stamp;
  import tels_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS     = 1500;
  localparam int TAIL_BEATS = 120;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_item;
  logic      out_strobe;
  out_beat_t out_item;

  int mismatches;
  int owed;
  int checked;

  int beats_sent;
  int messages;
  int echoes;
  int drops;
  int retries;
  int gap_style;

  tcp_echo_latency_stamp uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  tels_echo_checker echo_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .mismatches (mismatches),
    .owed       (owed),
    .checked    (checked)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop if the block hangs
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    b.func       = 3'($urandom_range(0, 7));
    b.session_id = 16'($urandom());
    b.value      = 16'($urandom());
    b.in_last    = 1'($urandom_range(0, 1));
    b.in_lane_0  = rand64();
    b.in_lane_1  = rand64();
    b.in_lane_2  = rand64();
    b.in_lane_3  = rand64();
    b.in_lane_4  = rand64();
    b.in_lane_5  = rand64();
    b.in_lane_6  = rand64();
    b.in_lane_7  = rand64();
    return b;
  endfunction

  function automatic in_beat_t make_beat(input logic [2:0] f, input logic [15:0] sess,
                                         input logic [15:0] val, input logic last);
    in_beat_t b;
    b            = random_beat();
    b.func       = f;
    b.session_id = sess;
    b.value      = val;
    b.in_last    = last;
    return b;
  endfunction

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (gap_style == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one beat at the falling edge and hold it until taken
  task automatic put_beat(input in_beat_t b);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      start   = 1'b0;
      in_item = random_beat();
    end
    @(negedge clk);
    in_item = b;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    beats_sent++;
  endtask

  // stop sending until every owed result beat has come back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    wait (owed == 0);
  endtask

  // events that the current phase must ignore
  task automatic stray_beats(input logic [2:0] advance);
    in_beat_t b;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = random_beat();
        while (b.func == advance) b.func = 3'($urandom_range(0, 7));
        // zero-length notification while waiting for one
        if (advance == FUNC_NOTIFY && $urandom_range(0, 1) == 1) begin
          b.func  = FUNC_NOTIFY;
          b.value = 16'd0;
        end
        put_beat(b);
      end
    end
  endtask

  // one full exchange: notify, rx, transmit request with status, echo
  task automatic echo_message(input logic [15:0] sess, input logic [15:0] len,
                              input int nwords);
    int r;
    logic [1:0] code;
    messages++;
    stray_beats(FUNC_NOTIFY);
    put_beat(make_beat(FUNC_NOTIFY, sess, len, 1'($urandom_range(0, 1))));
    stray_beats(FUNC_RXMETA);
    put_beat(make_beat(FUNC_RXMETA, 16'($urandom()), 16'($urandom()), 1'($urandom())));
    for (int w = 0; w < nwords; w++) begin
      stray_beats(FUNC_RXDATA);
      put_beat(make_beat(FUNC_RXDATA, 16'($urandom()), 16'($urandom()), w == nwords - 1));
    end
    forever begin
      // any beat lets the transmit request out
      put_beat(random_beat());
      stray_beats(FUNC_STATUS);
      r = $urandom_range(0, 99);
      code = (r < 70) ? STAT_SEND : (r < 82) ? STAT_DROP : 2'($urandom_range(2, 3));
      put_beat(make_beat(FUNC_STATUS, 16'($urandom()),
                         {14'($urandom()), code}, 1'($urandom())));
      if (code == STAT_SEND) begin
        echoes++;
        repeat ((nwords < MAX_WORDS_DEF) ? nwords : MAX_WORDS_DEF)
          put_beat(random_beat());
        break;
      end else if (code == STAT_DROP) begin
        drops++;
        break;
      end
      retries++;
    end
  endtask

  // extremes, every event kind, retries, drop, stray events, short message
  task automatic directed_cases();
    in_beat_t b;
    put_beat(make_beat(FUNC_NOTIFY, 16'h5555, 16'd0, 1'b0));
    put_beat(make_beat(3'd7, 16'hFFFF, 16'hFFFF, 1'b1));
    put_beat(make_beat(3'd5, 16'h0000, 16'h0040, 1'b0));
    put_beat(make_beat(FUNC_NOTIFY, 16'hFFFF, 16'd1, 1'b0));
    put_beat(make_beat(FUNC_STATUS, 16'h0000, 16'h0000, 1'b0));
    put_beat(make_beat(FUNC_RXMETA, 16'h0000, 16'h0000, 1'b0));
    b = make_beat(FUNC_RXDATA, 16'hFFFF, 16'hFFFF, 1'b1);
    b[511:0] = '1;
    put_beat(b);
    put_beat(make_beat(FUNC_IDLE, 16'h0000, 16'h0000, 1'b0));
    put_beat(make_beat(FUNC_STATUS, 16'h0000, 16'hFFFE, 1'b0));
    put_beat(make_beat(3'd6, 16'h0000, 16'h0000, 1'b0));
    put_beat(make_beat(FUNC_STATUS, 16'h0000, 16'h0003, 1'b0));
    put_beat(make_beat(FUNC_IDLE, 16'h0000, 16'h0000, 1'b0));
    put_beat(make_beat(FUNC_STATUS, 16'h0000, 16'hFFFC, 1'b0));
    put_beat(make_beat(FUNC_IDLE, 16'h0000, 16'h0000, 1'b0));
    // longest length is capped to the store size
    put_beat(make_beat(FUNC_NOTIFY, 16'h0000, 16'hFFFF, 1'b1));
    put_beat(make_beat(FUNC_RXMETA, 16'h0000, 16'h0000, 1'b0));
    b = make_beat(FUNC_RXDATA, 16'h0000, 16'h0000, 1'b0);
    b[511:0] = '0;
    put_beat(b);
    put_beat(make_beat(FUNC_RXDATA, 16'h0000, 16'h0000, 1'b1));
    put_beat(make_beat(FUNC_IDLE, 16'h0000, 16'h0000, 1'b0));
    put_beat(make_beat(FUNC_STATUS, 16'h0000, 16'h0001, 1'b0));
    // length beyond what was received
    put_beat(make_beat(FUNC_NOTIFY, 16'h1234, 16'd200, 1'b0));
    put_beat(make_beat(FUNC_RXMETA, 16'h0000, 16'h0000, 1'b0));
    put_beat(make_beat(FUNC_RXDATA, 16'h0000, 16'h0000, 1'b1));
    put_beat(make_beat(FUNC_IDLE, 16'h0000, 16'h0000, 1'b0));
    put_beat(make_beat(FUNC_STATUS, 16'h0000, 16'h0000, 1'b0));
    put_beat(make_beat(FUNC_IDLE, 16'h0000, 16'h0000, 1'b0));
  endtask

  initial begin
    int r;
    int len;
    int nwords;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    beats_sent = 0;
    messages   = 0;
    echoes     = 0;
    drops      = 0;
    retries    = 0;
    gap_style  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_cases();
    drain();

    // well-formed exchanges with random content, sizes mostly small
    while (beats_sent < ITEMS) begin
      gap_style = ($urandom_range(0, 3) == 0) ? 0 : 1;
      r = $urandom_range(0, 99);
      if (messages == 0) begin
        len    = 65535;
        nwords = 68;
      end else if (messages == 1) begin
        len    = 4096;
        nwords = 64;
      end else if (r < 70) begin
        len    = $urandom_range(1, 256);
        nwords = $urandom_range(0, 1) ? (len + 63) / 64 : $urandom_range(1, 5);
      end else if (r < 92) begin
        len    = $urandom_range(1, 1024);
        nwords = $urandom_range(0, 1) ? (len + 63) / 64 : $urandom_range(1, 16);
      end else begin
        len    = $urandom_range(1, 65535);
        nwords = $urandom_range(1, 70);
      end
      echo_message(16'($urandom()), 16'(len), nwords);
      if (messages % 15 == 7) drain();
    end

    // free-running noise to finish
    gap_style = 1;
    repeat (TAIL_BEATS) put_beat(random_beat());

    drain();
    repeat (8) @(posedge clk);

    $display("covered %0d beats over %0d exchanges: %0d echoed, %0d dropped, %0d retried",
             beats_sent, messages, echoes, drops, retries);
    $display("%0d result beats compared, %0d mismatches", checked, mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
